// ===== design/line_position_with_history_unit_assert.svh =====
// Assertion macros shared by the line position unit modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef LINE_POSITION_WITH_HISTORY_UNIT_ASSERT_SVH
`define LINE_POSITION_WITH_HISTORY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, disabled while the reset is asserted.
`define LPWH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, evaluated during reset as well.
`define LPWH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPWH_ASSERT(lbl, clk, rstn, prop, msg)
`define LPWH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/lpwh_pkg.sv =====
// Shared constants and controller/datapath interface types for the line position unit.
// Depends on nothing.
`timescale 1ns / 1ps

package lpwh_pkg;

    localparam int SENSOR_COUNT = 6;
    localparam int WEIGHT_W     = 8;
    localparam int POS_W        = 11;
    localparam int CFG_IDX_W    = 3;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_bits;
        logic calc_sum;
        logic push;
        logic set_zero;
        logic div_init;
        logic div_step;
        logic div_end;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any_active;
        logic empty;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ===== design/line_position_with_history_unit.sv =====
// Line position unit: an item with an active sensor, or with none and an empty history,
// goes through the sum state and then the push or zero state to the output register. With no
// active sensor and stored history the bit-serial divider runs SUM_W = 11 + clog2(HISTORY_DEPTH)
// steps (14 at depth 8). A new item is taken only once the last result is in the output register.
// Synchronous active-low reset clears weights, fill count, write index, running sum and
// the output valid; history entries are only read after they are written.
`timescale 1ns / 1ps

module line_position_with_history_unit #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lpwh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpwh_pkg::WEIGHT_W-1:0]      i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [5:0] sensor_bits, [7:6] ignored
    input  logic [lpwh_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [10:0] position, [15:11] zero
    output logic [lpwh_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // [0] from_history
    output logic [0:0]                         o_m_axis_tuser
);
    import lpwh_pkg::*;

    t_cmd             w_cmd;
    t_status          w_status;
    logic [POS_W-1:0] w_position;
    logic             w_from_history;

    lpwh_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    lpwh_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_sensor_bits  (i_s_axis_tdata[SENSOR_COUNT-1:0]),
        .i_m_tready     (i_m_axis_tready),
        .o_m_tvalid     (o_m_axis_tvalid),
        .o_position     (w_position),
        .o_from_history (w_from_history),
        .i_cmd          (w_cmd),
        .o_status       (w_status)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - POS_W){1'b0}}, w_position};
    assign o_m_axis_tuser = w_from_history;

endmodule

// ===== design/lpwh_ctrl.sv =====
// Sequencing state machine of the line position unit.
// Depends on lpwh_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "line_position_with_history_unit_assert.svh"

module lpwh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  lpwh_pkg::t_status i_status,
    output lpwh_pkg::t_cmd    o_cmd
);
    import lpwh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_PUSH,
        ST_ZERO,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   w_accept;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_bits = w_accept;
        o_cmd.calc_sum  = (r_state == ST_SUM);
        o_cmd.push      = (r_state == ST_PUSH);
        o_cmd.set_zero  = (r_state == ST_ZERO);
        o_cmd.div_init  = (r_state == ST_DIV_INIT);
        o_cmd.div_step  = (r_state == ST_DIV_RUN);
        o_cmd.div_end   = (r_state == ST_DIV_END);
        o_cmd.out_load  = (r_state == ST_DONE) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) r_state <= ST_SUM;
                end
                ST_SUM: begin
                    // The sensor bits were latched on the transfer, so status is valid here.
                    if (i_status.any_active)  r_state <= ST_PUSH;
                    else if (i_status.empty)  r_state <= ST_ZERO;
                    else                      r_state <= ST_DIV_INIT;
                end
                ST_PUSH:     r_state <= ST_DONE;
                ST_ZERO:     r_state <= ST_DONE;
                ST_DIV_INIT: r_state <= ST_DIV_RUN;
                ST_DIV_RUN: begin
                    if (i_status.div_last) r_state <= ST_DIV_END;
                end
                ST_DIV_END:  r_state <= ST_DONE;
                ST_DONE: begin
                    if (i_status.out_free) r_state <= ST_IDLE;
                end
                default:     r_state <= ST_IDLE;
            endcase
        end
    end

    `LPWH_ASSERT(a_accept_starts_sum, i_clk, i_rst_n, w_accept |=> (r_state == ST_SUM), "accepted item did not start the sum")
    `LPWH_ASSERT(a_load_needs_room, i_clk, i_rst_n, o_cmd.out_load |-> i_status.out_free, "result loaded while output register busy")
    `LPWH_ASSERT(a_run_from_init, i_clk, i_rst_n, $rose(o_cmd.div_step) |-> $past(o_cmd.div_init), "division started without initialization")

endmodule

// ===== design/lpwh_datapath.sv =====
// Datapath of the line position unit: weights, weighted sum, history memory,
// running sum, bit-serial divider and output register. Depends on lpwh_pkg.
`timescale 1ns / 1ps
`include "line_position_with_history_unit_assert.svh"

module lpwh_datapath #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lpwh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpwh_pkg::WEIGHT_W-1:0]      i_cfg_data,
    input  logic [lpwh_pkg::SENSOR_COUNT-1:0]  i_sensor_bits,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [lpwh_pkg::POS_W-1:0]         o_position,
    output logic                               o_from_history,
    input  lpwh_pkg::t_cmd                     i_cmd,
    output lpwh_pkg::t_status                  o_status
);
    import lpwh_pkg::*;

    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = POS_W + $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(SUM_W);

    logic signed [WEIGHT_W-1:0]     r_weight [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0]        r_bits;
    logic signed [POS_W-1:0]        r_sum;
    logic signed [POS_W-1:0]        n_sum;
    logic signed [POS_W-1:0]        r_mem [HISTORY_DEPTH];
    logic signed [POS_W-1:0]        r_rd;
    logic [FILL_W-1:0]              r_fill;
    logic [IDX_W-1:0]               r_widx;
    logic signed [SUM_W-1:0]        r_run;
    logic                           w_full;
    logic [IDX_W-1:0]               w_waddr;

    logic                           r_neg;
    logic [SUM_W-1:0]               r_dvd;
    logic [FILL_W-1:0]              r_rem;
    logic [CNT_W-1:0]               r_cnt;
    logic [FILL_W:0]                w_rem_sh;
    logic                           w_ge;

    logic signed [POS_W-1:0]        r_res_pos;
    logic                           r_res_flag;
    logic                           r_out_valid;
    logic signed [POS_W-1:0]        r_out_pos;
    logic                           r_out_flag;

    assign w_full  = (r_fill == FILL_W'(HISTORY_DEPTH));
    assign w_waddr = w_full ? r_widx : r_fill[IDX_W-1:0];

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (r_bits[i]) n_sum = n_sum + POS_W'(r_weight[i]);
        end
    end

    assign w_rem_sh = {r_rem, r_dvd[SUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_fill});

    assign o_status.any_active = (r_bits != '0);
    assign o_status.empty      = (r_fill == '0);
    assign o_status.div_last   = (r_cnt == CNT_W'(SUM_W - 1));
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    // History memory; the read port always follows the oldest slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_mem[w_waddr] <= r_sum;
        r_rd <= r_mem[r_widx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENSOR_COUNT; i++) r_weight[i] <= '0;
            r_fill      <= '0;
            r_widx      <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(SENSOR_COUNT))) begin
                r_weight[i_cfg_idx] <= i_cfg_data;
            end
            if (i_cmd.push) begin
                if (w_full) begin
                    // Replace the oldest entry, whose value is already in r_rd.
                    r_run <= r_run - SUM_W'(r_rd) + SUM_W'(r_sum);
                    if (r_widx == IDX_W'(HISTORY_DEPTH - 1)) r_widx <= '0;
                    else                                     r_widx <= r_widx + 1'b1;
                end else begin
                    r_run  <= r_run + SUM_W'(r_sum);
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.out_load)                 r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bits) r_bits <= i_sensor_bits;
        if (i_cmd.calc_sum)  r_sum  <= n_sum;
        if (i_cmd.push) begin
            r_res_pos  <= r_sum;
            r_res_flag <= 1'b0;
        end
        if (i_cmd.set_zero) begin
            r_res_pos  <= '0;
            r_res_flag <= 1'b1;
        end
        // Restoring division of the magnitude of the running sum by the fill count.
        if (i_cmd.div_init) begin
            r_neg <= r_run[SUM_W-1];
            r_dvd <= r_run[SUM_W-1] ? SUM_W'(-r_run) : SUM_W'(r_run);
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? FILL_W'(w_rem_sh - {1'b0, r_fill}) : w_rem_sh[FILL_W-1:0];
            r_dvd <= {r_dvd[SUM_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.div_end) begin
            r_res_pos  <= r_neg ? -r_dvd[POS_W-1:0] : r_dvd[POS_W-1:0];
            r_res_flag <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_pos  <= r_res_pos;
            r_out_flag <= r_res_flag;
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_from_history = r_out_flag;

    `LPWH_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(HISTORY_DEPTH), "fill count above history depth")
    `LPWH_ASSERT(a_wrap_only_full, i_clk, i_rst_n, (r_widx != '0) |-> w_full, "write index moved before history was full")
    `LPWH_ASSERT(a_rem_below_div, i_clk, i_rst_n, i_cmd.div_step |-> (r_rem < r_fill), "divider remainder not below divisor")

endmodule

// ===== dv/tb_line_position_with_history_unit.sv =====
// Self-checking testbench for line_position_with_history_unit: weighted sensor positions,
// history ring wrap and the truncating history average. Depends on lpwh_pkg and the unit.
`timescale 1ns / 1ps

module tb_line_position_with_history_unit;
    import lpwh_pkg::*;

    localparam int HISTORY_DEPTH = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 200;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_SCANS   = 55;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3,
        REG_WEIGHT_4, REG_WEIGHT_5, REG_SPARE_6, REG_SPARE_7
    } t_reg_idx;

    typedef enum int {WSTYLE_MAX, WSTYLE_MIN, WSTYLE_ZERO, WSTYLE_ALTERNATE, WSTYLE_RANDOM}
        t_weight_style;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_DENSE} t_sink_mode;

    class position_scoreboard;
        typedef struct {
            logic [POS_W-1:0] position;
            logic             from_history;
        } t_line_result;

        logic signed [WEIGHT_W-1:0] weight [SENSOR_COUNT];
        int history [HISTORY_DEPTH];
        int fill;
        int oldest;
        int total;
        t_line_result pending_q [$];
        int mismatches;

        function new();
            foreach (weight[i]) weight[i] = '0;
            foreach (history[i]) history[i] = 0;
            fill = 0;
            oldest = 0;
            total = 0;
            mismatches = 0;
        endfunction

        function void set_weight(t_reg_idx idx, logic [WEIGHT_W-1:0] value);
            if (idx <= REG_WEIGHT_5)
                weight[idx] = value;
        endfunction

        function void note_scan(logic [IN_TDATA_W-1:0] data);
            logic [SENSOR_COUNT-1:0] bits;
            int sum;
            int avg;
            t_line_result want;
            bits = data[SENSOR_COUNT-1:0];
            sum = 0;
            for (int i = 0; i < SENSOR_COUNT; i++)
                if (bits[i])
                    sum += weight[i];
            if (bits != '0) begin
                if (fill < HISTORY_DEPTH) begin
                    history[fill] = sum;
                    fill++;
                end else begin
                    total -= history[oldest];
                    history[oldest] = sum;
                    oldest = (oldest + 1) % HISTORY_DEPTH;
                end
                total += sum;
                want.position = sum[POS_W-1:0];
                want.from_history = 1'b0;
            end else begin
                // Integer division truncates toward zero, as the average must.
                avg = (fill == 0) ? 0 : total / fill;
                want.position = avg[POS_W-1:0];
                want.from_history = 1'b1;
            end
            pending_q.insert(pending_q.size(), want);
        endfunction

        function void check_output(logic [OUT_TDATA_W-1:0] tdata, logic [0:0] tuser);
            t_line_result want;
            logic [OUT_TDATA_W-1:0] want_data;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual position %0d flag %0b",
                         $time, $signed(tdata[POS_W-1:0]), tuser[0]);
                mismatches++;
            end else begin
                want = pending_q.pop_front();
                want_data = {{(OUT_TDATA_W - POS_W){1'b0}}, want.position};
                if (tdata !== want_data) begin
                    $display("%0t: position mismatch, expected %0d (0x%04h) actual %0d (0x%04h)",
                             $time, $signed(want.position), want_data,
                             $signed(tdata[POS_W-1:0]), tdata);
                    mismatches++;
                end
                if (tuser[0] !== want.from_history) begin
                    $display("%0t: from_history mismatch, expected %0b actual %0b",
                             $time, want.from_history, tuser[0]);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [WEIGHT_W-1:0]    i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [0:0]             o_m_axis_tuser;

    position_scoreboard sb = new();
    logic [WEIGHT_W-1:0] weight_plan [SENSOR_COUNT];
    int burst_left = 0;
    int scans_accepted = 0;
    int cycle_count = 0;

    line_position_with_history_unit #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void plan_weights(t_weight_style style);
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            case (style)
                WSTYLE_MAX:       weight_plan[i] = 8'h7F;
                WSTYLE_MIN:       weight_plan[i] = 8'h80;
                WSTYLE_ZERO:      weight_plan[i] = 8'h00;
                WSTYLE_ALTERNATE: weight_plan[i] = i[0] ? 8'h80 : 8'h7F;
                default:          weight_plan[i] = 8'($urandom);
            endcase
        end
    endfunction

    // Write enable stays high across the whole sequence of register writes.
    task automatic load_weights(input bit touch_spare);
        logic [WEIGHT_W-1:0] junk;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(i);
            i_cfg_data <= weight_plan[i];
            @(posedge i_clk);
            sb.set_weight(t_reg_idx'(i), weight_plan[i]);
        end
        if (touch_spare) begin
            junk = 8'($urandom);
            i_cfg_idx  <= REG_SPARE_6;
            i_cfg_data <= junk;
            @(posedge i_clk);
            sb.set_weight(REG_SPARE_6, junk);
            i_cfg_idx  <= REG_SPARE_7;
            i_cfg_data <= ~junk;
            @(posedge i_clk);
            sb.set_weight(REG_SPARE_7, ~junk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // The sender offers scans in bursts; a gap of idle cycles opens each burst.
    task automatic offer_scan(input logic [IN_TDATA_W-1:0] data);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_scan(data);
        scans_accepted++;
    endtask

    task automatic finish_phase();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] random_scan();
        logic [SENSOR_COUNT-1:0] bits;
        logic [IN_TDATA_W-SENSOR_COUNT-1:0] pad;
        pad = ($urandom_range(0, 7) == 0) ? (IN_TDATA_W - SENSOR_COUNT)'($urandom) : '0;
        case ($urandom_range(0, 9))
            0, 1, 2: bits = '0;
            3, 4:    bits = SENSOR_COUNT'(1) << $urandom_range(0, SENSOR_COUNT - 1);
            5:       bits = '1;
            default: bits = SENSOR_COUNT'($urandom);
        endcase
        return {pad, bits};
    endfunction

    // Receiver stall pattern, with one long hold-off once traffic is under way.
    initial begin : sink_pattern
        t_sink_mode mode;
        int span;
        bit held;
        held = 1'b0;
        forever begin
            if (!held && scans_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            mode = t_sink_mode'($urandom_range(0, 3));
            span = $urandom_range(8, 64);
            repeat (span) begin
                case (mode)
                    SINK_OPEN:   i_m_axis_tready <= 1'b1;
                    SINK_COIN:   i_m_axis_tready <= 1'($urandom);
                    SINK_SPARSE: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default:     i_m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_output(o_m_axis_tdata, o_m_axis_tuser);
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_WEIGHT_0;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset weights: empty history average, then a zero sum pushed and averaged.
        offer_scan(8'h00);
        offer_scan(8'h3F);
        offer_scan(8'h00);
        finish_phase();

        // Largest weights; the spare indexes are written and must be ignored.
        plan_weights(WSTYLE_MAX);
        load_weights(1'b1);
        offer_scan(8'h3F);
        offer_scan(8'h01);
        offer_scan(8'h00);
        offer_scan(8'hC0);   // only the padding bits are set, so no sensor is active
        offer_scan(8'hFF);
        finish_phase();

        // Smallest weights; enough pushes to wrap the history ring.
        plan_weights(WSTYLE_MIN);
        load_weights(1'b0);
        repeat (7) offer_scan(8'h3F);
        offer_scan(8'h00);
        offer_scan(8'h2A);
        offer_scan(8'h00);
        finish_phase();

        // Distinct weights, one sensor at a time, then a negative average.
        weight_plan[0] = 8'h01;
        weight_plan[1] = 8'hFE;
        weight_plan[2] = 8'h03;
        weight_plan[3] = 8'hFB;
        weight_plan[4] = 8'h07;
        weight_plan[5] = 8'hF5;
        load_weights(1'b0);
        for (int i = 0; i < SENSOR_COUNT; i++)
            offer_scan(IN_TDATA_W'(1) << i);
        offer_scan(8'h00);
        finish_phase();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < WSTYLE_RANDOM)
                plan_weights(t_weight_style'(p));
            else
                plan_weights(WSTYLE_RANDOM);
            load_weights(($urandom_range(0, 2) == 0));
            repeat (PHASE_SCANS) offer_scan(random_scan());
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lpwh_pkg.sv
design/lpwh_ctrl.sv
design/lpwh_datapath.sv
design/line_position_with_history_unit.sv
dv/tb_line_position_with_history_unit.sv
